// ===== rtl/medn_pkg.sv =====
package medn_pkg;

	localparam int MAX_MEMBERS = 4;
	localparam int FIELD_LIMIT = (MAX_MEMBERS < 4) ? MAX_MEMBERS : 4;
	localparam int TABLE_DEPTH = 4096;
	localparam int MEMBER_BITS = 24;
	localparam int IN_BITS     = 24;
	localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
	localparam int TOTAL_BITS  = ADDR_BITS + 1;
	localparam int NUM_BITS    = 14;
	localparam int RANK_BITS   = $clog2(FIELD_LIMIT) + 1;

	typedef struct packed {
		logic [2:0]                member_count;
		logic signed [IN_BITS-1:0] member_a;
		logic signed [IN_BITS-1:0] member_b;
		logic signed [IN_BITS-1:0] member_c;
		logic signed [IN_BITS-1:0] member_d;
		logic                      last_in_element;
	} item_t;

	typedef struct packed {
		logic signed [NUM_BITS-1:0] entity_number;
		logic                       was_new;
		logic                       table_full;
		logic                       element_done;
	} result_t;

	// Canonical key as stored in the table
	typedef struct packed {
		logic [2:0]                                count;
		logic [FIELD_LIMIT-1:0][MEMBER_BITS-1:0]   members;
	} entry_t;

	// Classified item handed from front to back
	typedef struct packed {
		entry_t key;
		logic   negate;
		logic   last;
	} key_t;

endpackage

// ===== rtl/medn_front.sv =====
module medn_front
	import medn_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	output logic  key_valid,
	input  logic  key_ready,
	output key_t  key
);

	logic  valid_s1;
	item_t item_s1;

	logic signed [IN_BITS-1:0] raw [4];
	logic [2:0]                n;
	logic [IN_BITS+1:0]        mag [FIELD_LIMIT];
	logic [RANK_BITS-1:0]      rank [FIELD_LIMIT];
	logic [IN_BITS:0]          wide;
	logic [MEMBER_BITS-1:0]    val;

	assign full      = valid_s1 && !key_ready;
	assign key_valid = valid_s1;

	// Hold one item until the key queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			item_s1 <= item;
		end
	end

	// Clamp count, rank members by magnitude (stable), negate if needed
	always_comb begin
		raw[0] = item_s1.member_a;
		raw[1] = item_s1.member_b;
		raw[2] = item_s1.member_c;
		raw[3] = item_s1.member_d;
		if (item_s1.member_count == 3'd0) begin
			n = 3'd1;
		end else if (item_s1.member_count > 3'(FIELD_LIMIT)) begin
			n = 3'(FIELD_LIMIT);
		end else begin
			n = item_s1.member_count;
		end
		for (int i = 0; i < FIELD_LIMIT; i++) begin
			wide = {raw[i][IN_BITS-1], raw[i]};
			if (raw[i][IN_BITS-1]) begin
				wide = -wide;
			end
			mag[i] = {(3'(i) >= n), wide};
		end
		for (int i = 0; i < FIELD_LIMIT; i++) begin
			rank[i] = '0;
			for (int j = 0; j < FIELD_LIMIT; j++) begin
				if (j < i && mag[j] <= mag[i]) begin
					rank[i] = rank[i] + 1'b1;
				end else if (j > i && mag[j] < mag[i]) begin
					rank[i] = rank[i] + 1'b1;
				end
			end
		end
		key.negate = 1'b0;
		for (int i = 0; i < FIELD_LIMIT; i++) begin
			if (rank[i] == '0) begin
				key.negate = raw[i][IN_BITS-1];
			end
		end
		key.key.count = n;
		for (int p = 0; p < FIELD_LIMIT; p++) begin
			key.key.members[p] = '0;
			for (int i = 0; i < FIELD_LIMIT; i++) begin
				val = MEMBER_BITS'(raw[i]);
				if (key.negate) begin
					val = -val;
				end
				if (rank[i] == RANK_BITS'(p) && 3'(i) < n) begin
					key.key.members[p] = val;
				end
			end
		end
		key.last = item_s1.last_in_element;
	end

endmodule

// ===== rtl/medn_keyq.sv =====
module medn_keyq
	import medn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  key_t wr_data,
	output logic rd_valid,
	input  logic rd_pop,
	output key_t rd_data
);

	key_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = slot_q[rptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= !wptr_q;
			end
			if (do_rd) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/medn_back.sv =====
module medn_back
	import medn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    key_valid,
	output logic    key_pop,
	input  key_t    key,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_CHECK  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                state_q;
	logic [TOTAL_BITS-1:0] idx_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [31:0]           elements_q;
	logic                  hit_q;
	entry_t                ram [TABLE_DEPTH];
	entry_t                rd_q;

	result_t    res_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       res_push;
	logic       res_pop;
	logic       room;
	logic       do_insert;
	logic [TOTAL_BITS-1:0] num;
	result_t    res_new;

	assign room      = (cnt_q != 2'd2);
	assign res_push  = (state_q == ST_FINISH) && room;
	assign key_pop   = res_push;
	assign do_insert = res_push && !hit_q && (total_q < TOTAL_BITS'(TABLE_DEPTH));
	assign res_pop   = pop && !empty;
	assign empty     = (cnt_q == 2'd0);
	assign result    = res_q[rptr_q];

	// Build the result transaction
	always_comb begin
		if (hit_q) begin
			num = idx_q + 1'b1;
		end else if (total_q < TOTAL_BITS'(TABLE_DEPTH)) begin
			num = total_q + 1'b1;
		end else begin
			num = '0;
		end
		res_new.entity_number = key.negate ? -NUM_BITS'(num) : NUM_BITS'(num);
		res_new.was_new       = do_insert;
		res_new.table_full    = !hit_q && !do_insert;
		res_new.element_done  = key.last;
	end

	// Scan the table one entry at a time, each entry passing through SCAN and CHECK
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			total_q    <= '0;
			elements_q <= '0;
			hit_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (key_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == total_q) begin
						hit_q   <= 1'b0;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (rd_q == key.key) begin
						hit_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_FINISH: begin
					if (res_push) begin
						if (do_insert) begin
							total_q <= total_q + 1'b1;
						end
						if (key.last) begin
							elements_q <= elements_q + 32'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Key table: one write, one registered read
	always_ff @(posedge clk) begin
		rd_q <= ram[idx_q[ADDR_BITS-1:0]];
		if (do_insert) begin
			ram[total_q[ADDR_BITS-1:0]] <= key.key;
		end
	end

	// Result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (res_push) begin
				wptr_q <= !wptr_q;
			end
			if (res_pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, res_push} - {1'b0, res_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[wptr_q] <= res_new;
		end
	end

endmodule

// ===== rtl/mesh_entity_dedup_numbering.sv =====
// Channel  | Handshake            | Payload
// input    | push / full          | item   (item_t)
// result   | pop / empty          | result (result_t)
//
// Each item is matched by a linear scan over the N keys stored in the key
// table, through its single read port.
// The front canonicalizes in one register stage; a two-entry key queue and
// a two-entry result queue let input and output stall independently.
// Reset (arst_n) clears counts and queues; table contents need no clearing.
module mesh_entity_dedup_numbering
	import medn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic f_valid;
	logic f_ready;
	key_t f_key;
	logic b_valid;
	logic b_pop;
	key_t b_key;

	medn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.key_valid (f_valid),
		.key_ready (f_ready),
		.key       (f_key)
	);

	medn_keyq u_keyq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_key),
		.rd_valid (b_valid),
		.rd_pop   (b_pop),
		.rd_data  (b_key)
	);

	medn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (b_valid),
		.key_pop   (b_pop),
		.key       (b_key),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
